// File: design/jsu_pkg.sv
// Package for the JSON string unescape block: request types, scan modes,
// result kinds, error codes, character codes and small helper functions.
// No dependencies.
`default_nettype none

package jsu_pkg;

  localparam int MaxRes = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_end;
  } txt_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [3:0] error_code;
    logic       last;
  } res_t;

  typedef res_t [MaxRes-1:0] res_quad_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_BODY    = 3'd1,
    MODE_ESC     = 3'd2,
    MODE_HEX     = 3'd3,
    MODE_WANT_BS = 3'd4,
    MODE_WANT_U  = 3'd5,
    MODE_HEX_LO  = 3'd6
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [1:0]  cnt;
    logic [15:0] acc;
    logic [9:0]  hi;
  } scan_t;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_NO_OPEN   = 4'd1;
  localparam logic [3:0] ERR_UNTERM    = 4'd2;
  localparam logic [3:0] ERR_UNTERM_ES = 4'd3;
  localparam logic [3:0] ERR_BAD_ESC   = 4'd4;
  localparam logic [3:0] ERR_CONTROL   = 4'd5;
  localparam logic [3:0] ERR_TRUNC_HEX = 4'd6;
  localparam logic [3:0] ERR_BAD_HEX   = 4'd7;
  localparam logic [3:0] ERR_BAD_PAIR  = 4'd8;
  localparam logic [3:0] ERR_LONE_LOW  = 4'd9;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  function automatic res_t mk_res(logic [7:0] b, logic [1:0] k, logic [3:0] code);
    res_t r;
    r.out_byte   = b;
    r.kind       = k;
    r.error_code = code;
    r.last       = 1'b0;
    return r;
  endfunction

  // Bit 4 set means not a hex digit.
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b0, c[3:0] + 4'd9};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// File: design/jsu_decode.sv
// Combinational decode of one request against the scan state: next state
// and up to four results (UTF-8 bytes, close or error).
// Depends on jsu_pkg.
`default_nettype none

module jsu_decode (
  input  jsu_pkg::scan_t     st,
  input  jsu_pkg::txt_t      item,
  output jsu_pkg::scan_t     st_next,
  output logic [2:0]         cnt,
  output jsu_pkg::res_quad_t quad
);

  logic [7:0]  c;
  logic        fin;
  logic        err;
  logic [3:0]  code;
  logic        enc;
  logic [20:0] cp;
  logic [4:0]  hv;
  logic [15:0] acc_new;
  logic [10:0] hi_sum;

  assign c       = item.in_byte;
  assign fin     = item.text_end;
  assign hv      = jsu_pkg::hex_val(c);
  assign acc_new = {st.acc[11:0], hv[3:0]};
  assign hi_sum  = {1'b0, st.hi} + 11'd64;

  always_comb begin
    st_next = st;
    cnt     = 3'd0;
    quad    = '0;
    err     = 1'b0;
    code    = jsu_pkg::ERR_NONE;
    enc     = 1'b0;
    cp      = '0;

    unique case (st.mode) inside
      jsu_pkg::MODE_BODY: begin
        if (fin) begin
          err  = 1'b1;
          code = jsu_pkg::ERR_UNTERM;
        end else if (c == jsu_pkg::CH_QUOTE) begin
          st_next.mode = jsu_pkg::MODE_IDLE;
          cnt          = 3'd1;
          quad[0]      = jsu_pkg::mk_res(8'd0, jsu_pkg::KIND_CLOSE, jsu_pkg::ERR_NONE);
        end else if (c == jsu_pkg::CH_BSLASH) begin
          st_next.mode = jsu_pkg::MODE_ESC;
        end else if (c < jsu_pkg::CH_SPACE) begin
          err  = 1'b1;
          code = jsu_pkg::ERR_CONTROL;
        end else begin
          cnt     = 3'd1;
          quad[0] = jsu_pkg::mk_res(c, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
        end
      end
      jsu_pkg::MODE_ESC: begin
        if (fin) begin
          err  = 1'b1;
          code = jsu_pkg::ERR_UNTERM_ES;
        end else begin
          st_next.mode = jsu_pkg::MODE_BODY;
          cnt          = 3'd1;
          case (c) inside
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
              quad[0] = jsu_pkg::mk_res(c, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            jsu_pkg::CH_B: quad[0] = jsu_pkg::mk_res(8'h08, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            jsu_pkg::CH_F: quad[0] = jsu_pkg::mk_res(8'h0C, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            jsu_pkg::CH_N: quad[0] = jsu_pkg::mk_res(8'h0A, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            jsu_pkg::CH_R: quad[0] = jsu_pkg::mk_res(8'h0D, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            jsu_pkg::CH_T: quad[0] = jsu_pkg::mk_res(8'h09, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            jsu_pkg::CH_U: begin
              cnt          = 3'd0;
              st_next.mode = jsu_pkg::MODE_HEX;
              st_next.cnt  = 2'd0;
              st_next.acc  = 16'd0;
            end
            default: begin
              cnt  = 3'd0;
              err  = 1'b1;
              code = jsu_pkg::ERR_BAD_ESC;
            end
          endcase
        end
      end
      jsu_pkg::MODE_HEX, jsu_pkg::MODE_HEX_LO: begin
        if (fin) begin
          err  = 1'b1;
          code = jsu_pkg::ERR_TRUNC_HEX;
        end else if (hv[4]) begin
          err  = 1'b1;
          code = jsu_pkg::ERR_BAD_HEX;
        end else begin
          st_next.acc = acc_new;
          if (st.cnt != 2'd3) begin
            st_next.cnt = st.cnt + 2'd1;
          end else begin
            st_next.cnt = 2'd0;
            if (st.mode == jsu_pkg::MODE_HEX_LO) begin
              if (acc_new[15:10] != 6'b110111) begin
                err  = 1'b1;
                code = jsu_pkg::ERR_BAD_PAIR;
              end else begin
                st_next.mode = jsu_pkg::MODE_BODY;
                enc          = 1'b1;
                cp           = {hi_sum, acc_new[9:0]};
              end
            end else if (acc_new[15:10] == 6'b110110) begin
              st_next.hi   = acc_new[9:0];
              st_next.mode = jsu_pkg::MODE_WANT_BS;
            end else if (acc_new[15:10] == 6'b110111) begin
              err  = 1'b1;
              code = jsu_pkg::ERR_LONE_LOW;
            end else begin
              st_next.mode = jsu_pkg::MODE_BODY;
              enc          = 1'b1;
              cp           = {5'd0, acc_new};
            end
          end
        end
      end
      jsu_pkg::MODE_WANT_BS: begin
        if (fin || c != jsu_pkg::CH_BSLASH) begin
          err  = 1'b1;
          code = jsu_pkg::ERR_BAD_PAIR;
        end else begin
          st_next.mode = jsu_pkg::MODE_WANT_U;
        end
      end
      jsu_pkg::MODE_WANT_U: begin
        if (fin || c != jsu_pkg::CH_U) begin
          err  = 1'b1;
          code = jsu_pkg::ERR_BAD_PAIR;
        end else begin
          st_next.mode = jsu_pkg::MODE_HEX_LO;
          st_next.cnt  = 2'd0;
          st_next.acc  = 16'd0;
        end
      end
      default: begin
        if (!fin && c == jsu_pkg::CH_QUOTE) begin
          st_next.mode = jsu_pkg::MODE_BODY;
        end else begin
          err  = 1'b1;
          code = jsu_pkg::ERR_NO_OPEN;
        end
      end
    endcase

    if (enc) begin
      if (cp[20:7] == '0) begin
        cnt     = 3'd1;
        quad[0] = jsu_pkg::mk_res(cp[7:0], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      end else if (cp[20:11] == '0) begin
        cnt     = 3'd2;
        quad[0] = jsu_pkg::mk_res({3'b110, cp[10:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
        quad[1] = jsu_pkg::mk_res({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      end else if (cp[20:16] == '0) begin
        cnt     = 3'd3;
        quad[0] = jsu_pkg::mk_res({4'b1110, cp[15:12]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
        quad[1] = jsu_pkg::mk_res({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
        quad[2] = jsu_pkg::mk_res({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      end else begin
        cnt     = 3'd4;
        quad[0] = jsu_pkg::mk_res({5'b11110, cp[20:18]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
        quad[1] = jsu_pkg::mk_res({2'b10, cp[17:12]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
        quad[2] = jsu_pkg::mk_res({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
        quad[3] = jsu_pkg::mk_res({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      end
    end

    if (err) begin
      st_next.mode = jsu_pkg::MODE_IDLE;
      cnt          = 3'd1;
      quad[0]      = jsu_pkg::mk_res(8'd0, jsu_pkg::KIND_ERROR, code);
    end
  end

endmodule

`default_nettype wire

// File: design/json_string_unescape.sv
// Top level of the JSON string unescape block: input register, scan state,
// result buffer of up to four entries drained one per cycle while res_ready is high.
// Depends on jsu_pkg and jsu_decode.
//
//   channel | signals                          | moves
//   txt     | txt_valid, txt_ready, txt        | one raw text byte or end mark
//   res     | res_valid, res_ready, res        | one decoded byte, close or error
//
// One request per cycle when each gives a single result and res is not stalled.
// A request that gives several results keeps the next request waiting while the
// buffer drains: a four-byte UTF-8 code point stalls txt until its bytes drain.
// Each request is decoded from the input register into the result buffer.
// Reset clears the scan state and empties the input register and the result buffer.
// A stall on res backs up into txt_ready once the input register is full.
`default_nettype none

module json_string_unescape (
  input  logic           clk,
  input  logic           rst,
  input  logic           txt_valid,
  output logic           txt_ready,
  input  jsu_pkg::txt_t  txt,
  output logic           res_valid,
  input  logic           res_ready,
  output jsu_pkg::res_t  res
);

  logic               hold_vld;
  jsu_pkg::txt_t      hold;
  jsu_pkg::scan_t     st;
  jsu_pkg::scan_t     st_next;
  logic [2:0]         cnt;
  jsu_pkg::res_quad_t quad;
  jsu_pkg::res_quad_t ent;
  logic [2:0]         rem;
  logic [1:0]         idx;
  logic               consume;

  jsu_decode u_decode (
    .st      (st),
    .item    (hold),
    .st_next (st_next),
    .cnt     (cnt),
    .quad    (quad)
  );

  assign res_valid = (rem != 3'd0);
  assign consume   = hold_vld && ((rem == 3'd0) || (rem == 3'd1 && res_ready));
  assign txt_ready = !hold_vld || consume;

  always_comb begin
    res      = ent[idx];
    res.last = (rem == 3'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vld <= 1'b0;
      st       <= '{mode: jsu_pkg::MODE_IDLE, cnt: 2'd0, acc: 16'd0, hi: 10'd0};
      rem      <= 3'd0;
      idx      <= 2'd0;
    end else begin
      if (txt_valid && txt_ready) begin
        hold_vld <= 1'b1;
      end else if (consume) begin
        hold_vld <= 1'b0;
      end
      if (consume) begin
        st  <= st_next;
        rem <= cnt;
        idx <= 2'd0;
      end else if (res_valid && res_ready) begin
        rem <= rem - 3'd1;
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (txt_valid && txt_ready) begin
      hold <= txt;
    end
    if (consume) begin
      ent <= quad;
    end
  end

endmodule

`default_nettype wire

// File: design/jsu_check.sv
// Port-level checks for json_string_unescape and the bind that attaches them.
// Depends on jsu_pkg and json_string_unescape.
`default_nettype none

module jsu_check (
  input logic          clk,
  input logic          rst,
  input logic          txt_ready,
  input logic          res_valid,
  input logic          res_ready,
  input jsu_pkg::res_t res
);

  a_rst_empty: assert property (@(posedge clk) rst |=> (!res_valid && txt_ready))
    else $error("result valid or input blocked right after reset");

  a_single: assert property (@(posedge clk) disable iff (rst)
      (res_valid && res.kind != jsu_pkg::KIND_DATA) |-> res.last)
    else $error("close or error not the only result of its request");

  a_burst: assert property (@(posedge clk) disable iff (rst)
      (res_valid && res_ready && !res.last) |=> res_valid)
    else $error("gap inside a multi-byte burst");

  a_hold: assert property (@(posedge clk) disable iff (rst)
      (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("stalled result dropped or changed");

endmodule

bind json_string_unescape jsu_check u_jsu_check (
  .clk       (clk),
  .rst       (rst),
  .txt_ready (txt_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

`default_nettype wire
